FILE: rtl/assert_macros.svh
// Assertion helpers used by linked_block_allocator_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lba_pkg.sv
package lba_pkg;

  // Table geometry
  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 512;
  localparam int AW          = $clog2(NUM_BLOCKS);  // block address bits
  localparam int BW          = 9;                   // block number incl. "none"
  localparam int CW          = 2;                   // command / status width
  localparam int BYTES_W     = 18;
  localparam int NEED_W      = BYTES_W + 1;

  localparam logic [BW-1:0] NONE_LINK = BW'(NUM_BLOCKS);

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Commands
  localparam logic [CW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CW-1:0] CMD_FREE  = 2'd1;
  localparam logic [CW-1:0] CMD_QUERY = 2'd2;

  // Status codes
  localparam logic [CW-1:0] STAT_OK      = 2'd0;
  localparam logic [CW-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [CW-1:0] STAT_RANGE   = 2'd2;

  // One table entry: in-use bit and next link
  typedef struct packed {
    logic          used;
    logic [BW-1:0] link;
  } entry_t;

  localparam int ENTRY_W = BW + 1;
  localparam entry_t ENTRY_RESET = '{used: 1'b0, link: NONE_LINK};

  // Sequencer to table access
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: rtl/lba_ram.sv
module lba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lba_table.sv
module lba_table (
  input  logic              clk,
  input  logic              rst,
  input  lba_pkg::tbl_req_t req,
  output lba_pkg::entry_t   rd
);
  import lba_pkg::*;

  logic [NUM_BLOCKS-1:0] valid;
  logic [ENTRY_W-1:0]    ram_q;
  logic                  vld_q;
  logic                  hit_q;
  entry_t                byp_q;

  lba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  // Written-once flags; an unwritten entry reads as the reset entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      hit_q <= req.we && (req.waddr == req.raddr);
    end
  end

  // Read-side companions of the RAM output
  always_ff @(posedge clk) begin
    vld_q <= valid[req.raddr];
    byp_q <= req.wdata;
  end

  // Same-cycle write wins over the stored copy
  always_comb begin
    if (hit_q) begin
      rd = byp_q;
    end else if (vld_q) begin
      rd = entry_t'(ram_q);
    end else begin
      rd = ENTRY_RESET;
    end
  end

endmodule

FILE: rtl/linked_block_allocator_unit.sv
// Linked block allocator: block table with an in-use bit and a next link per block.
// Input stream s_*: s_tuser = cmd (allocate / free / query), s_tdata carries the
// byte count and the block index. Output stream m_*: one beat per command, with
// the chain head, queried link and in-use bit, freed count, free-block count,
// and the status code in m_tuser. cfg_we / cfg_wdata set the active block count.
// Each command starts with a counting pass over the active blocks, then allocate
// scans the table once more, free walks the chain one block per cycle (at most
// 256 steps), and query reads the entry of the given block. The block table has
// a single read port, visited one entry per cycle.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the block returns to idle and takes
// the next command while it waits, and a stalled receiver holds only the
// following result. Reset marks all blocks unused with no links (cleared by
// per-entry valid flags) and sets the active count to 256.
module linked_block_allocator_unit (
  input  logic                           clk,
  input  logic                           rst,
  // config
  input  logic                           cfg_we,
  input  logic [lba_pkg::BW-1:0]         cfg_wdata,   // active_blocks
  // command stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lba_pkg::IN_TDATA_W-1:0] s_tdata,     // byte_count, block_index
  input  logic [lba_pkg::CW-1:0]         s_tuser,     // cmd
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // chain_head, next_link, block_used, freed_count, free_blocks
  output logic [lba_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [lba_pkg::CW-1:0]         m_tuser      // status
);
  import lba_pkg::*;

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_COUNT     = 3'd1;
  localparam logic [2:0] ST_EXEC      = 3'd2;
  localparam logic [2:0] ST_ALLOC     = 3'd3;
  localparam logic [2:0] ST_ALLOC_END = 3'd4;
  localparam logic [2:0] ST_FREE      = 3'd5;
  localparam logic [2:0] ST_QUERY     = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  logic [2:0]        state;
  logic [BW-1:0]     active;
  logic [CW-1:0]     cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [BW-1:0]     bidx_q;
  logic [BW-1:0]     scan;
  logic [AW-1:0]     addr_q;
  logic              pend;
  logic [BW-1:0]     free_cnt;
  logic [BW-1:0]     got;
  logic [BW-1:0]     need_q;
  logic [BW-1:0]     prev;
  logic [BW-1:0]     first;
  logic [BW-1:0]     cur;
  logic [BW-1:0]     steps;
  logic [BW-1:0]     freed;
  logic [BW-1:0]     qlink;
  logic              qused;
  logic [CW-1:0]     status;

  logic [BW-1:0]     lim;
  logic              issue_scan;
  logic [NEED_W-1:0] need_full;
  logic              found;
  logic [BW-1:0]     got_inc;
  logic [BW-1:0]     step_inc;
  logic              out_load;
  tbl_req_t          req;
  entry_t            rd;

  lba_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rd  (rd)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Shared compare / count datapath
  always_comb begin
    lim        = (active > NONE_LINK) ? NONE_LINK : active;
    issue_scan = (scan < lim);
    need_full  = NEED_W'((NEED_W'(bytes_q) + NEED_W'(BLOCK_BYTES - 1)) / BLOCK_BYTES);
    found      = pend && !rd.used;
    got_inc    = got + BW'(1);
    step_inc   = steps + BW'(1);
  end

  // Table access per state
  always_comb begin
    req.we    = 1'b0;
    req.waddr = '0;
    req.wdata = ENTRY_RESET;
    req.raddr = scan[AW-1:0];
    unique case (state)
      ST_EXEC: begin
        req.raddr = bidx_q[AW-1:0];
      end
      ST_ALLOC: begin
        if (found && (prev != NONE_LINK)) begin
          req.we    = 1'b1;
          req.waddr = prev[AW-1:0];
          req.wdata = '{used: 1'b1, link: {1'b0, addr_q}};
        end
      end
      ST_ALLOC_END: begin
        req.we    = 1'b1;
        req.waddr = prev[AW-1:0];
        req.wdata = '{used: 1'b1, link: NONE_LINK};
      end
      ST_FREE: begin
        req.raddr = rd.link[AW-1:0];
        if (rd.used) begin
          req.we    = 1'b1;
          req.waddr = cur[AW-1:0];
          req.wdata = '{used: 1'b0, link: rd.link};
        end
      end
      default: begin
      end
    endcase
  end

  // Control: sequencer state, config register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      active   <= NONE_LINK;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (!issue_scan && !pend) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_q)
            CMD_ALLOC: begin
              if ((NEED_W'(free_cnt) < need_full) || (need_full == '0)) begin
                state <= ST_DONE;
              end else begin
                state <= ST_ALLOC;
              end
            end
            CMD_FREE: begin
              if ((bidx_q == NONE_LINK) || (bidx_q >= lim)) begin
                state <= ST_DONE;
              end else begin
                state <= ST_FREE;
              end
            end
            CMD_QUERY: begin
              state <= (bidx_q < lim) ? ST_QUERY : ST_DONE;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_ALLOC: begin
          if (found && (got_inc == need_q)) begin
            state <= ST_ALLOC_END;
          end
        end
        ST_ALLOC_END: begin
          state <= ST_DONE;
        end
        ST_FREE: begin
          if ((rd.link == NONE_LINK) || (rd.link >= lim) ||
              (step_inc == BW'(NUM_BLOCKS))) begin
            state <= ST_DONE;
          end
        end
        ST_QUERY: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({free_cnt, freed, qused, qlink, first});
      m_tuser <= status;
    end
    unique case (state)
      ST_IDLE: begin
        cmd_q    <= s_tuser;
        bytes_q  <= s_tdata[BYTES_W-1:0];
        bidx_q   <= s_tdata[BYTES_W +: BW];
        scan     <= '0;
        pend     <= 1'b0;
        free_cnt <= '0;
        freed    <= '0;
        status   <= STAT_OK;
        first    <= NONE_LINK;
        qlink    <= NONE_LINK;
        qused    <= 1'b0;
      end
      ST_COUNT: begin
        pend <= issue_scan;
        if (issue_scan) begin
          scan   <= scan + BW'(1);
          addr_q <= scan[AW-1:0];
        end
        if (found) begin
          free_cnt <= free_cnt + BW'(1);
        end
      end
      ST_EXEC: begin
        scan   <= '0;
        pend   <= 1'b0;
        got    <= '0;
        prev   <= NONE_LINK;
        need_q <= need_full[BW-1:0];
        cur    <= bidx_q;
        steps  <= '0;
        if ((cmd_q == CMD_ALLOC) && (NEED_W'(free_cnt) < need_full)) begin
          status <= STAT_NOSPACE;
        end else if (((cmd_q == CMD_FREE) && (bidx_q != NONE_LINK) && (bidx_q >= lim)) ||
                     ((cmd_q == CMD_QUERY) && (bidx_q >= lim))) begin
          status <= STAT_RANGE;
        end
      end
      ST_ALLOC: begin
        pend <= issue_scan;
        if (issue_scan) begin
          scan   <= scan + BW'(1);
          addr_q <= scan[AW-1:0];
        end
        if (found) begin
          got      <= got_inc;
          free_cnt <= free_cnt - BW'(1);
          prev     <= {1'b0, addr_q};
          if (prev == NONE_LINK) begin
            first <= {1'b0, addr_q};
          end
        end
      end
      ST_FREE: begin
        steps <= step_inc;
        cur   <= rd.link;
        if (rd.used) begin
          freed    <= freed + BW'(1);
          free_cnt <= free_cnt + BW'(1);
        end
        if ((rd.link != NONE_LINK) && (rd.link >= lim)) begin
          status <= STAT_RANGE;
        end
      end
      ST_QUERY: begin
        qlink <= rd.link;
        qused <= rd.used;
      end
      default: begin
      end
    endcase
  end

  // Checks
  `CHK_IMPL(a_alloc_short, clk, rst, state == ST_ALLOC, got < need_q, "alloc overran need")
  `CHK_IMPL(a_free_bound, clk, rst, state == ST_FREE, (steps < BW'(NUM_BLOCKS)) && (cur < lim), "free walk out of bounds")
  `CHK_NEXT(a_alloc_head, clk, rst, state == ST_ALLOC_END, (state == ST_DONE) && (first != NONE_LINK), "alloc ended without head")
  `CHK_IMPL(a_nospace_nochain, clk, rst, m_tvalid && (m_tuser == STAT_NOSPACE), m_tdata[BW-1:0] == NONE_LINK, "refused alloc returned a chain")

endmodule

FILE: tb/allocator_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the config port, keeps its own copy of the
// block table and compares every result beat with the predicted one.
module allocator_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lba_pkg::BW-1:0]          cfg_wdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lba_pkg::IN_TDATA_W-1:0]  s_tdata,    // byte_count, block_index
  input  logic [lba_pkg::CW-1:0]          s_tuser,    // cmd
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // chain_head, next_link, block_used, freed_count, free_blocks
  input  logic [lba_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic [lba_pkg::CW-1:0]          m_tuser,    // status
  output int                              mismatches,
  output int                              outstanding
);
  import lba_pkg::*;

  typedef struct {
    logic [BW-1:0] chain_head;
    logic [BW-1:0] next_link;
    logic          block_used;
    logic [BW-1:0] freed_count;
    logic [BW-1:0] free_blocks;
    logic [CW-1:0] status;
  } reply_t;

  // Shadow table and active block count (already clipped to NUM_BLOCKS)
  logic          busy_map [NUM_BLOCKS];
  logic [BW-1:0] next_map [NUM_BLOCKS];
  int unsigned   disk_blocks;
  reply_t        replies_due [$];
  reply_t        due;

  function automatic int unsigned unused_blocks();
    int unsigned n;
    n = 0;
    for (int i = 0; i < disk_blocks; i++)
      if (!busy_map[i]) n++;
    return n;
  endfunction

  // Applies one command to the shadow table, returns the reply it yields
  function automatic reply_t apply_command(logic [CW-1:0] cmd, logic [BYTES_W-1:0] bytes,
                                           logic [BW-1:0] idx);
    reply_t      r;
    int unsigned need, got, prev, cur, nx, steps;
    bit          walking;
    r.chain_head  = NONE_LINK;
    r.next_link   = NONE_LINK;
    r.block_used  = 1'b0;
    r.freed_count = '0;
    r.status      = STAT_OK;
    case (cmd)
      CMD_ALLOC: begin
        need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (unused_blocks() < need) begin
          r.status = STAT_NOSPACE;
        end else if (need > 0) begin
          // first fit, ascending, each claimed block linked to the next
          prev = NUM_BLOCKS;
          got  = 0;
          for (int i = 0; i < disk_blocks && got < need; i++) begin
            if (!busy_map[i]) begin
              busy_map[i] = 1'b1;
              if (prev == NUM_BLOCKS) r.chain_head = BW'(i);
              else next_map[prev] = BW'(i);
              prev = i;
              got++;
            end
          end
          if (prev != NUM_BLOCKS) next_map[prev] = NONE_LINK;
        end
      end
      CMD_FREE: begin
        if (idx != NONE_LINK) begin
          if (idx >= disk_blocks) begin
            r.status = STAT_RANGE;
          end else begin
            // walk the chain; links stay, a link off the disk stops the walk
            cur     = idx;
            steps   = 0;
            walking = 1'b1;
            while (walking && steps < NUM_BLOCKS) begin
              if (busy_map[cur]) begin
                busy_map[cur] = 1'b0;
                r.freed_count++;
              end
              steps++;
              nx = next_map[cur];
              if (nx == NUM_BLOCKS) begin
                walking = 1'b0;
              end else if (nx >= disk_blocks) begin
                r.status = STAT_RANGE;
                walking  = 1'b0;
              end else begin
                cur = nx;
              end
            end
          end
        end
      end
      CMD_QUERY: begin
        if (idx < disk_blocks) begin
          r.next_link  = next_map[idx];
          r.block_used = busy_map[idx];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      default: ;
    endcase
    r.free_blocks = BW'(unused_blocks());
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        busy_map[i] = 1'b0;
        next_map[i] = NONE_LINK;
      end
      disk_blocks = NUM_BLOCKS;
      replies_due.delete();
    end else begin
      if (cfg_we)
        disk_blocks = (cfg_wdata > NUM_BLOCKS) ? NUM_BLOCKS : cfg_wdata;
      // result beat: match against the oldest pending reply
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing pending, tdata %h tuser %0d",
                     $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          check_field("chain_head",  due.chain_head,  m_tdata[8:0]);
          check_field("next_link",   due.next_link,   m_tdata[17:9]);
          check_field("block_used",  due.block_used,  m_tdata[18]);
          check_field("freed_count", due.freed_count, m_tdata[27:19]);
          check_field("free_blocks", due.free_blocks, m_tdata[36:28]);
          check_field("status",      due.status,      m_tuser);
        end
      end
      // command beat
      if (s_tvalid && s_tready)
        replies_due.push_back(apply_command(s_tuser, s_tdata[BYTES_W-1:0],
                                            s_tdata[BYTES_W +: BW]));
    end
    outstanding <= replies_due.size();
  end

endmodule

FILE: tb/linked_block_allocator_unit_test.sv
`timescale 1ns / 100ps

module linked_block_allocator_unit_test;
  import lba_pkg::*;

  localparam logic [CW-1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD = 1500;
  localparam int MAX_BYTES = NUM_BLOCKS * BLOCK_BYTES;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [BW-1:0]          cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [CW-1:0]          s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [CW-1:0]          m_tuser;

  int          mismatches;
  int          outstanding;
  int          send_idle  = 0;
  int          recv_stall = 0;
  int unsigned disk_size  = NUM_BLOCKS;
  logic        hold_req;
  logic        hold_ack;

  linked_block_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  allocator_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_ack = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_ack) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_ack <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // One command beat, with optional idle cycles ahead of it
  task automatic issue(input logic [CW-1:0] cmd, input int unsigned bytes,
                       input int unsigned idx);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_TDATA_W'({BW'(idx), BYTES_W'(bytes)});
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain all pending results, then write the active block count
  task automatic set_disk(input int unsigned blocks);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= BW'(blocks);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    disk_size = blocks;
  endtask

  // Mostly well-formed commands on existing blocks, some noise
  task automatic random_item();
    int unsigned   pick, bytes, idx;
    logic [CW-1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CMD_ALLOC;
    else if (pick < 75) cmd = CMD_FREE;
    else if (pick < 95) cmd = CMD_QUERY;
    else cmd = CMD_UNUSED;
    pick = $urandom_range(99);
    if (pick < 5) bytes = 0;
    else if (pick < 70) bytes = $urandom_range(1, 4) * BLOCK_BYTES - 1 + $urandom_range(2);
    else if (pick < 90) bytes = $urandom_range(disk_size * BLOCK_BYTES);
    else if (pick < 93) bytes = MAX_BYTES;
    else bytes = $urandom_range(MAX_BYTES);
    pick = $urandom_range(99);
    if (pick < 80) idx = $urandom_range(disk_size - 1);
    else if (pick < 90) idx = NONE_LINK;
    else idx = $urandom_range(NUM_BLOCKS);
    issue(cmd, bytes, idx);
  endtask

  task automatic run_phase(input int unsigned blocks, input int idle_pct,
                           input int stall_pct, input int count);
    set_disk(blocks);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (count) random_item();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_ALLOC;
    hold_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fresh table, size edges, refusal, free of none, repeated free
    issue(CMD_QUERY, 0, 0);
    issue(CMD_QUERY, 0, NONE_LINK);
    issue(CMD_ALLOC, 0, 0);
    issue(CMD_ALLOC, 1, 0);
    issue(CMD_ALLOC, BLOCK_BYTES + 1, 0);
    issue(CMD_ALLOC, MAX_BYTES, 0);
    issue(CMD_QUERY, 0, 1);
    issue(CMD_FREE, 0, NONE_LINK);
    issue(CMD_FREE, 0, 1);
    issue(CMD_FREE, 0, 1);
    issue(CMD_QUERY, 0, 2);
    issue(CMD_UNUSED, MAX_BYTES, 255);
    issue(CMD_FREE, 0, 0);
    // whole disk in one chain, then full refusal and full release
    issue(CMD_ALLOC, MAX_BYTES, 0);
    issue(CMD_QUERY, 0, 255);
    issue(CMD_ALLOC, 1, 0);
    issue(CMD_FREE, 0, 0);

    // single-block disk, missing block
    set_disk(1);
    issue(CMD_QUERY, 0, 1);
    issue(CMD_ALLOC, BLOCK_BYTES, 0);
    issue(CMD_ALLOC, 1, 0);
    issue(CMD_FREE, 0, 0);

    // chain that runs off a shrunk disk
    set_disk(NUM_BLOCKS);
    issue(CMD_ALLOC, 200 * BLOCK_BYTES, 0);
    set_disk(100);
    issue(CMD_FREE, 0, 0);
    issue(CMD_FREE, 0, 150);
    issue(CMD_QUERY, 0, 100);
    set_disk(NUM_BLOCKS);
    issue(CMD_FREE, 0, 100);

    // random phases across disk sizes and idle patterns
    run_phase(NUM_BLOCKS, 0, 0, 200);
    run_phase(37, 73, 0, 200);
    run_phase(NUM_BLOCKS, 0, 73, 150);
    run_phase(1, 35, 35, 60);
    run_phase(100, 35, 35, 200);

    // back-pressure: long receiver hold while commands keep coming
    set_disk(16);
    send_idle  = 0;
    recv_stall = 0;
    hold_req <= 1'b1;
    repeat (150) random_item();

    run_phase(200, 0, 0, 185);

    // drain and verdict
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lba_pkg.sv
rtl/lba_ram.sv
rtl/lba_table.sv
rtl/linked_block_allocator_unit.sv
tb/allocator_checker.sv
tb/linked_block_allocator_unit_test.sv
